/* rtl/core/trs_pkg.sv */
// shared constants, types and helpers of the trs model matrix builder
package trs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ZW           = 34;
  localparam int NST          = CORDIC_STEPS + 9;

  localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768
  };

  localparam logic [1:0] LAST_COL = 2'd3;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [31:0] q16_t;
  typedef logic signed [23:0] scl_t;

  function automatic q15_t rnd_sat16(input logic signed [ZW-1:0] v);
    logic signed [ZW-1:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'sd32767;
    else if (t < -34'sd32768) return -16'sd32768;
    else return t[15:0];
  endfunction

  function automatic q16_t rnd_sat32(input logic signed [57:0] v);
    logic signed [57:0] t;
    t = (v + 58'sd536870912) >>> 30;
    if (t > 58'sd2147483647) return 32'sh7fffffff;
    else if (t < -58'sd2147483648) return 32'sh80000000;
    else return t[31:0];
  endfunction

endpackage

/* rtl/core/trs_chan_if.sv */
// request and result channels of the trs model matrix builder
interface trs_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic signed [23:0] scale_x;
  logic signed [23:0] scale_y;
  logic signed [23:0] scale_z;
  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  column_index;
  logic signed [31:0] elem_row0;
  logic signed [31:0] elem_row1;
  logic signed [31:0] elem_row2;
  logic        last;
  modport source (output valid, column_index, elem_row0, elem_row1, elem_row2, last,
                  input ready);
  modport sink (input valid, column_index, elem_row0, elem_row1, elem_row2, last,
                output ready);
endinterface

/* rtl/core/trs_model_matrix_build_unit.sv */
// trs model matrix builder: pipelined cordic sine/cosine, rotation and scale
// the output stage sends columns 0 to 3, one column per cycle while ready is high
// the pipeline takes new requests while the output stage still sends four columns
// the 16-stage cordic pipeline takes a new request in any cycle it is not stalled
// reset clears the pipeline and output valid bits and the column count only
module trs_model_matrix_build_unit
  import trs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  trs_in_if.sink     in_chan,
  trs_out_if.source  out_chan
);

  logic [NST-1:0] v_r;
  logic en, ser_free, load;

  logic signed [31:0] pd_r [NST][3];
  scl_t               sd_r [NST][3];
  logic signed [15:0] ang [3];

  logic signed [ZW-1:0] az_r [3];
  logic signed [ZW-1:0] wz_r [3];
  logic signed [ZW-1:0] cx_r [CORDIC_STEPS+1][3];
  logic signed [ZW-1:0] cy_r [CORDIC_STEPS+1][3];
  logic signed [ZW-1:0] cz_r [CORDIC_STEPS+1][3];
  logic                 cn_r [CORDIC_STEPS+1][3];

  q15_t s_r [3];
  q15_t c_r [3];
  q15_t sx2_r, cx2_r, sy2_r;

  logic signed [31:0] p_czcy_r, p_czsy_r, p_szcx_r, p_szsx_r, p_szcy_r;
  logic signed [31:0] p_szsy_r, p_czcx_r, p_czsx_r, p_cysx_r, p_cycx_r;

  logic signed [47:0] r_r   [3][3];
  logic signed [ZW-1:0] r30_r [3][3];
  logic signed [57:0] m_r   [3][3];
  q16_t               el_r  [3][3];

  logic         ser_v_r;
  logic [1:0]   col_r;
  q16_t         sm_r [3][3];
  q16_t         sp_r [3];

  assign ang[0] = in_chan.angle_x;
  assign ang[1] = in_chan.angle_y;
  assign ang[2] = in_chan.angle_z;

  assign ser_free = !ser_v_r || (out_chan.ready && col_r == LAST_COL);
  assign en       = !v_r[NST-1] || ser_free;
  assign load     = v_r[NST-1] && ser_free;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0][0] <= in_chan.pos_x;
      pd_r[0][1] <= in_chan.pos_y;
      pd_r[0][2] <= in_chan.pos_z;
      sd_r[0][0] <= in_chan.scale_x;
      sd_r[0][1] <= in_chan.scale_y;
      sd_r[0][2] <= in_chan.scale_z;
      for (int s = 1; s < NST; s++) begin
        pd_r[s] <= pd_r[s-1];
        sd_r[s] <= sd_r[s-1];
      end

      for (int l = 0; l < 3; l++) begin
        az_r[l] <= ZW'(ang[l]) <<< 17;
        // wrap into one turn
        if (az_r[l] > PI_Q30) wz_r[l] <= az_r[l] - TWO_PI_Q30;
        else if (az_r[l] < -PI_Q30) wz_r[l] <= az_r[l] + TWO_PI_Q30;
        else wz_r[l] <= az_r[l];
        // fold into the right half plane
        cx_r[0][l] <= CORDIC_GAIN;
        cy_r[0][l] <= '0;
        if (wz_r[l] > HALF_PI_Q30) begin
          cz_r[0][l] <= wz_r[l] - PI_Q30;
          cn_r[0][l] <= 1'b1;
        end else if (wz_r[l] < -HALF_PI_Q30) begin
          cz_r[0][l] <= wz_r[l] + PI_Q30;
          cn_r[0][l] <= 1'b1;
        end else begin
          cz_r[0][l] <= wz_r[l];
          cn_r[0][l] <= 1'b0;
        end
        for (int s = 0; s < CORDIC_STEPS; s++) begin
          cn_r[s+1][l] <= cn_r[s][l];
          if (!cz_r[s][l][ZW-1]) begin
            cx_r[s+1][l] <= cx_r[s][l] - (cy_r[s][l] >>> s);
            cy_r[s+1][l] <= cy_r[s][l] + (cx_r[s][l] >>> s);
            cz_r[s+1][l] <= cz_r[s][l] - ATAN_Q30[s];
          end else begin
            cx_r[s+1][l] <= cx_r[s][l] + (cy_r[s][l] >>> s);
            cy_r[s+1][l] <= cy_r[s][l] - (cx_r[s][l] >>> s);
            cz_r[s+1][l] <= cz_r[s][l] + ATAN_Q30[s];
          end
        end
        if (cn_r[CORDIC_STEPS][l]) begin
          c_r[l] <= rnd_sat16(-cx_r[CORDIC_STEPS][l]);
          s_r[l] <= rnd_sat16(-cy_r[CORDIC_STEPS][l]);
        end else begin
          c_r[l] <= rnd_sat16(cx_r[CORDIC_STEPS][l]);
          s_r[l] <= rnd_sat16(cy_r[CORDIC_STEPS][l]);
        end
      end

      // pairwise products
      p_czcy_r <= 32'(c_r[2] * c_r[1]);
      p_czsy_r <= 32'(c_r[2] * s_r[1]);
      p_szcx_r <= 32'(s_r[2] * c_r[0]);
      p_szsx_r <= 32'(s_r[2] * s_r[0]);
      p_szcy_r <= 32'(s_r[2] * c_r[1]);
      p_szsy_r <= 32'(s_r[2] * s_r[1]);
      p_czcx_r <= 32'(c_r[2] * c_r[0]);
      p_czsx_r <= 32'(c_r[2] * s_r[0]);
      p_cysx_r <= 32'(c_r[1] * s_r[0]);
      p_cycx_r <= 32'(c_r[1] * c_r[0]);
      sx2_r    <= s_r[0];
      cx2_r    <= c_r[0];
      sy2_r    <= s_r[1];

      // rotation in q45
      r_r[0][0] <= 48'(p_czcy_r) <<< 15;
      r_r[0][1] <= 48'(p_czsy_r * sx2_r) - (48'(p_szcx_r) <<< 15);
      r_r[0][2] <= 48'(p_czsy_r * cx2_r) + (48'(p_szsx_r) <<< 15);
      r_r[1][0] <= 48'(p_szcy_r) <<< 15;
      r_r[1][1] <= 48'(p_szsy_r * sx2_r) + (48'(p_czcx_r) <<< 15);
      r_r[1][2] <= 48'(p_szsy_r * cx2_r) - (48'(p_czsx_r) <<< 15);
      r_r[2][0] <= -(48'(sy2_r) <<< 30);
      r_r[2][1] <= 48'(p_cysx_r) <<< 15;
      r_r[2][2] <= 48'(p_cycx_r) <<< 15;

      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          r30_r[k][j] <= ZW'((r_r[k][j] + 48'sd16384) >>> 15);
          m_r[k][j]   <= 58'(r30_r[k][j]) * 58'(sd_r[NST-3][j]);
          el_r[k][j]  <= rnd_sat32(m_r[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      col_r   <= '0;
    end else if (load) begin
      ser_v_r <= 1'b1;
      col_r   <= '0;
    end else if (out_chan.valid && out_chan.ready) begin
      col_r <= col_r + 2'd1;
      if (col_r == LAST_COL) ser_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) sm_r[j][k] <= el_r[k][j];
      end
      sp_r <= pd_r[NST-1];
    end
  end

  assign out_chan.valid        = ser_v_r;
  assign out_chan.column_index = col_r;
  assign out_chan.last         = (col_r == LAST_COL);

  always_comb begin
    case (col_r)
      2'd0: begin
        out_chan.elem_row0 = sm_r[0][0];
        out_chan.elem_row1 = sm_r[0][1];
        out_chan.elem_row2 = sm_r[0][2];
      end
      2'd1: begin
        out_chan.elem_row0 = sm_r[1][0];
        out_chan.elem_row1 = sm_r[1][1];
        out_chan.elem_row2 = sm_r[1][2];
      end
      2'd2: begin
        out_chan.elem_row0 = sm_r[2][0];
        out_chan.elem_row1 = sm_r[2][1];
        out_chan.elem_row2 = sm_r[2][2];
      end
      default: begin
        out_chan.elem_row0 = sp_r[0];
        out_chan.elem_row1 = sp_r[1];
        out_chan.elem_row2 = sp_r[2];
      end
    endcase
  end

endmodule

/* verif/trs_model_matrix_build_unit_test.sv */
// self-checking testbench of the trs model matrix builder: column prediction and compare
`timescale 1ns / 1ps
module trs_model_matrix_build_unit_test;
  import trs_pkg::*;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] elem_row0;
    logic signed [31:0] elem_row1;
    logic signed [31:0] elem_row2;
    logic               last;
  } column_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [15:0] ang [3];
    logic signed [23:0] scl [3];
  } pose_t;

  localparam longint GAIN   = 652032874;
  localparam longint PI_V   = 64'sd3373259426;
  localparam longint HALF_V = 1686629713;
  localparam longint ATAN_V [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  trs_in_if  in_chan ();
  trs_out_if out_chan ();

  trs_model_matrix_build_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  column_t expected_columns [$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_cycles = 0;

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  task automatic sin_cos(input logic signed [15:0] a, output longint s, output longint c);
    longint z, x, y, t, dx, dy;
    bit flip;
    z = longint'(a) * 131072;
    x = GAIN;
    y = 0;
    flip = 0;
    if (z > PI_V) z -= 2 * PI_V;
    else if (z < -PI_V) z += 2 * PI_V;
    if (z > HALF_V) begin
      z -= PI_V;
      flip = 1;
    end else if (z < -HALF_V) begin
      z += PI_V;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        t = x - dx;
        y = y + dy;
        z -= ATAN_V[i];
      end else begin
        t = x + dx;
        y = y - dy;
        z += ATAN_V[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_l(round_shift(x, 15), -32768, 32767);
    s = clamp_l(round_shift(y, 15), -32768, 32767);
  endtask

  task automatic predict_columns(input pose_t p);
    longint sx, cx, sy, cy, sz, cz, v;
    longint r [3][3];
    longint e [3];
    column_t col;
    sin_cos(p.ang[0], sx, cx);
    sin_cos(p.ang[1], sy, cy);
    sin_cos(p.ang[2], sz, cz);
    r[0][0] = cz * cy * 32768;
    r[0][1] = cz * sy * sx - sz * cx * 32768;
    r[0][2] = cz * sy * cx + sz * sx * 32768;
    r[1][0] = sz * cy * 32768;
    r[1][1] = sz * sy * sx + cz * cx * 32768;
    r[1][2] = sz * sy * cx - cz * sx * 32768;
    r[2][0] = -sy * 1073741824;
    r[2][1] = cy * sx * 32768;
    r[2][2] = cy * cx * 32768;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (j < 3) begin
          v = round_shift(round_shift(r[k][j], 15) * longint'(p.scl[j]), 30);
          e[k] = clamp_l(v, -64'sd2147483648, 64'sd2147483647);
        end else begin
          e[k] = p.pos[k];
        end
      end
      col.column_index = 2'(j);
      col.elem_row0 = e[0][31:0];
      col.elem_row1 = e[1][31:0];
      col.elem_row2 = e[2][31:0];
      col.last = (2'(j) == LAST_COL);
      expected_columns.push_back(col);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.pos_z = '0;
    in_chan.angle_x = '0;
    in_chan.angle_y = '0;
    in_chan.angle_z = '0;
    in_chan.scale_x = '0;
    in_chan.scale_y = '0;
    in_chan.scale_z = '0;
    out_chan.ready = 1'b0;
  end

  // receiver side with random idling and long hold-offs
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    column_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_columns.size() == 0) begin
        report_mismatch("unexpected column", out_chan.column_index, -1);
      end else begin
        want = expected_columns.pop_front();
        if (out_chan.column_index !== want.column_index)
          report_mismatch("column_index", out_chan.column_index, want.column_index);
        if (out_chan.elem_row0 !== want.elem_row0)
          report_mismatch("elem_row0", out_chan.elem_row0, want.elem_row0);
        if (out_chan.elem_row1 !== want.elem_row1)
          report_mismatch("elem_row1", out_chan.elem_row1, want.elem_row1);
        if (out_chan.elem_row2 !== want.elem_row2)
          report_mismatch("elem_row2", out_chan.elem_row2, want.elem_row2);
        if (out_chan.last !== want.last)
          report_mismatch("last", out_chan.last, want.last);
      end
    end
  end

  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.pos_x <= p.pos[0];
    in_chan.pos_y <= p.pos[1];
    in_chan.pos_z <= p.pos[2];
    in_chan.angle_x <= p.ang[0];
    in_chan.angle_y <= p.ang[1];
    in_chan.angle_z <= p.ang[2];
    in_chan.scale_x <= p.scl[0];
    in_chan.scale_y <= p.scl[1];
    in_chan.scale_z <= p.scl[2];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_columns(p);
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    for (int k = 0; k < 3; k++) begin
      p.pos[k] = $urandom;
      case ($urandom_range(3))
        0: p.ang[k] = 16'($urandom);
        1: p.ang[k] = 16'($signed($urandom_range(51472)) - 25736);
        2: p.ang[k] = 16'($signed($urandom_range(12868 + 400)) - 200);
        default: p.ang[k] = 16'($signed($urandom_range(400)) - 200 + 12868);
      endcase
      case ($urandom_range(3))
        0: p.scl[k] = 24'($urandom);
        1: p.scl[k] = 24'($signed($urandom_range(1 << 20)) - (1 << 19));
        2: p.scl[k] = 24'sd65536;
        default: p.scl[k] = ($urandom_range(1)) ? 24'sh7fffff : 24'sh800000;
      endcase
    end
    return p;
  endfunction

  function automatic pose_t uniform_pose(input logic signed [31:0] pv,
                                         input logic signed [15:0] av,
                                         input logic signed [23:0] sv);
    pose_t p;
    for (int k = 0; k < 3; k++) begin
      p.pos[k] = pv;
      p.ang[k] = av;
      p.scl[k] = sv;
    end
    return p;
  endfunction

  task automatic test_extremes();
    logic signed [15:0] angles [10] = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd25736,
      -16'sd25736, 16'sd25740, -16'sd25740, 16'sd12868, -16'sd12868, 16'sd1};
    send_pose(uniform_pose(32'sd0, 16'sd0, 24'sd65536));
    send_pose(uniform_pose(32'sh7fffffff, 16'sd0, 24'sh7fffff));
    send_pose(uniform_pose(32'sh80000000, 16'sd0, 24'sh800000));
    send_pose(uniform_pose(-32'sd1, 16'sd0, -24'sd1));
    foreach (angles[i]) send_pose(uniform_pose($urandom, angles[i], 24'sh7fffff));
    foreach (angles[i]) begin
      pose_t p;
      p = random_pose();
      p.ang[i % 3] = angles[i];
      send_pose(p);
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_pose(random_pose());
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(20);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (expected_columns.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 31;
    recv_idle_pct = 65;
    test_extremes();
    test_random(110);
    send_idle_pct = 65;
    recv_idle_pct = 31;
    test_random(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(110);
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
